@@ src/mmmv_pkg.sv @@
package mmmv_pkg;

    // Default depth of the window store.
    localparam int DEFAULT_WINDOW_MAX = 64;

    // Widths fixed by the register and payload fields.
    localparam int SAMPLE_W  = 32;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_VALUE = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0]    WINDOW_LEN_RESET    = 7'd3;
    localparam logic [SAMPLE_W-1:0] MISSING_VALUE_RESET = 32'h8000_0000;

endpackage

@@ src/mmmv_ram.sv @@
module mmmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/moving_mean_with_missing_values.sv @@
// Channel  Handshake               Payload
// -------  ----------------------  ---------------------------------------
// input    in_valid / in_stall     sample[31:0], series_start
// output   out_valid / out_stall   mean[31:0], mean_missing
// config   cfg_we                  cfg_index, cfg_data[31:0]
//
// A missing result (warm-up or missing current sample) skips sum and divide.
// For an averaged item the window is summed through the single read port of
// the store, one entry a cycle, then a radix-2 divider takes one quotient bit
// a cycle for SW = 32 + clog2(WINDOW_MAX + 1) bits. Reset clears all control
// state; the store needs no clearing. in_stall is high while an item is at
// work; a result waits in the output register while out_stall is high.
module moving_mean_with_missing_values
    import mmmv_pkg::*;
#(
    parameter int WINDOW_MAX = DEFAULT_WINDOW_MAX
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 series_start,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SAMPLE_W-1:0]  mean,
    output logic                 mean_missing
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam int DW = $clog2(SW + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW_MAX);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    window_len_reg;
    logic [SAMPLE_W-1:0] missing_value_reg;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       seen_reg, seen_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]       acc_cnt_reg, acc_cnt_next;
    logic                rd_vld_reg;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [SW-1:0]       q_reg, q_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                miss_reg, miss_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic                mean_missing_reg, mean_missing_next;

    logic                accept;
    logic [CW-1:0]       len_eff;
    logic [AW-1:0]       wp_eff;
    logic [AW-1:0]       wp_inc;
    logic [CW-1:0]       seen_new;
    logic                rd_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic [CW:0]         r_ext;
    logic [CW:0]         r_sub;
    logic                r_ge;
    logic [SW-1:0]       q_neg;
    logic [SW-1:0]       sum_neg;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Effective window length: zero counts as one, large values saturate.
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (int'(window_len_reg) > WINDOW_MAX)
        begin
            len_eff = CNT_MAX;
        end
        else
        begin
            len_eff = CW'(window_len_reg);
        end
    end

    // Write position and sample count for the incoming item.
    assign wp_eff   = series_start ? '0 : wp_reg;
    assign wp_inc   = (wp_eff == PTR_LAST) ? '0 : wp_eff + AW'(1);
    assign seen_new = series_start ? CW'(1) :
                      (seen_reg == CNT_MAX) ? seen_reg : seen_reg + CW'(1);

    // Window store.
    mmmv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_eff),
        .wdata (sample),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // One restoring division step and the sign fix-ups.
    assign r_ext   = {rem_reg, q_reg[SW-1]};
    assign r_sub   = r_ext - {1'b0, cnt_reg};
    assign r_ge    = (r_ext >= {1'b0, cnt_reg});
    assign q_neg   = ~q_reg + SW'(1);
    assign sum_neg = ~sum_reg + SW'(1);

    assign rd_en = (state_reg == S_SUM) && (issue_cnt_reg != len_reg);

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        seen_next         = seen_reg;
        len_next          = len_reg;
        issue_cnt_next    = issue_cnt_reg;
        acc_cnt_next      = acc_cnt_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        step_next         = step_reg;
        rd_ptr_next       = rd_ptr_reg;
        q_next            = q_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        miss_next         = miss_reg;
        mean_next         = mean_reg;
        mean_missing_next = mean_missing_reg;
        out_valid_next    = out_valid_reg;

        // The waiting result leaves on a transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next        = wp_inc;
                    seen_next      = seen_new;
                    len_next       = len_eff;
                    rd_ptr_next    = wp_eff;
                    issue_cnt_next = '0;
                    acc_cnt_next   = '0;
                    sum_next       = '0;
                    cnt_next       = '0;
                    if (seen_new < len_eff || sample == missing_value_reg)
                    begin
                        miss_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        miss_next  = 1'b0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                // Walk back from the newest entry, one read a cycle.
                if (rd_en)
                begin
                    rd_ptr_next    = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - AW'(1);
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_data != missing_value_reg)
                    begin
                        sum_next = sum_reg + {{(SW-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
                        cnt_next = cnt_reg + CW'(1);
                    end
                    acc_cnt_next = acc_cnt_reg + CW'(1);
                    if (acc_cnt_reg == len_reg - CW'(1))
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                if (cnt_reg == '0)
                begin
                    miss_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    neg_next   = sum_reg[SW-1];
                    q_next     = sum_reg[SW-1] ? sum_neg : sum_reg;
                    rem_next   = '0;
                    step_next  = DW'(SW);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = r_ge ? r_sub[CW-1:0] : r_ext[CW-1:0];
                q_next    = {q_reg[SW-2:0], r_ge};
                step_next = step_reg - DW'(1);
                if (step_reg == DW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    mean_missing_next = miss_reg;
                    if (miss_reg)
                    begin
                        mean_next = missing_value_reg;
                    end
                    else
                    begin
                        mean_next = neg_reg ? q_neg[SAMPLE_W-1:0] : q_reg[SAMPLE_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            window_len_reg    <= WINDOW_LEN_RESET;
            missing_value_reg <= MISSING_VALUE_RESET;
            wp_reg            <= '0;
            seen_reg          <= '0;
            len_reg           <= '0;
            issue_cnt_reg     <= '0;
            acc_cnt_reg       <= '0;
            rd_vld_reg        <= 1'b0;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            seen_reg      <= seen_next;
            len_reg       <= len_next;
            issue_cnt_reg <= issue_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            rd_vld_reg    <= rd_en;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LEN:    window_len_reg    <= cfg_data[LEN_W-1:0];
                    REG_MISSING_VALUE: missing_value_reg <= cfg_data;
                    default:           window_len_reg    <= window_len_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rd_ptr_reg       <= rd_ptr_next;
        q_reg            <= q_next;
        rem_reg          <= rem_next;
        neg_reg          <= neg_next;
        miss_reg         <= miss_next;
        mean_reg         <= mean_next;
        mean_missing_reg <= mean_missing_next;
    end

    assign out_valid    = out_valid_reg;
    assign mean         = mean_reg;
    assign mean_missing = mean_missing_reg;

`ifndef SYNTH
    // An accepted item always puts the sequencer to work.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after an accepted item");

    // Reads never run past the window length.
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> issue_cnt_reg <= len_reg)
        else $error("window read count exceeds the window length");

    // Every accumulated entry was read first.
    a_acc_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> acc_cnt_reg <= issue_cnt_reg)
        else $error("accumulated more entries than were read");

    // The divider never runs with a zero count.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg != '0)
        else $error("division started with a zero count");

    // A finished result is not dropped while the output is stalled.
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> state_reg == S_DONE)
        else $error("result left the sequencer while the output was held");
`endif

endmodule

@@ tb/tb_moving_mean_with_missing_values.sv @@
`timescale 1ns / 1ps

module tb_moving_mean_with_missing_values;
    import mmmv_pkg::*;

    localparam int  DEPTH       = DEFAULT_WINDOW_MAX;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  PHASE_ITEMS = 130;
    localparam int  PHASES      = 8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic                missing;
    } mean_result_t;

    // Scoreboard: keeps its own window of samples and the register copies,
    // predicts the mean of each accepted sample and checks the results in order.
    class mean_scoreboard;
        logic [SAMPLE_W-1:0] window[DEPTH];
        int                  wr_ptr;
        int                  seen;
        logic [LEN_W-1:0]    win_len;
        logic [SAMPLE_W-1:0] miss_val;
        mean_result_t        expected_means[$];
        int                  mismatch_count;

        function new();
            foreach (window[i])
                window[i] = '0;
            wr_ptr         = 0;
            seen           = 0;
            win_len        = WINDOW_LEN_RESET;
            miss_val       = MISSING_VALUE_RESET;
            mismatch_count = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            if (idx == REG_WINDOW_LEN)
                win_len = data[LEN_W-1:0];
            else if (idx == REG_MISSING_VALUE)
                miss_val = data;
        endfunction

        function void predict_mean(logic [SAMPLE_W-1:0] s, logic start);
            int           len;
            int           idx;
            longint       total;
            longint       cnt;
            bit           miss;
            mean_result_t r;
            len = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
            // A new series forgets all history before the sample is stored.
            if (start)
            begin
                seen   = 0;
                wr_ptr = 0;
            end
            window[wr_ptr] = s;
            if (seen < DEPTH)
                seen++;
            miss  = (seen < len) || (s == miss_val);
            total = 0;
            cnt   = 0;
            if (!miss)
            begin
                // Sum the valid samples of the trailing window, newest first.
                for (int k = 0; k < len; k++)
                begin
                    idx = (wr_ptr + DEPTH - k) % DEPTH;
                    if (window[idx] != miss_val)
                    begin
                        total += longint'($signed(window[idx]));
                        cnt++;
                    end
                end
                if (cnt == 0)
                    miss = 1'b1;
            end
            wr_ptr = (wr_ptr + 1) % DEPTH;
            r.missing = miss;
            r.mean    = miss ? miss_val : SAMPLE_W'(total / cnt);
            expected_means.push_back(r);
        endfunction

        function void check_mean(logic [SAMPLE_W-1:0] mean, logic missing);
            mean_result_t r;
            if (expected_means.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result mean=%h missing=%b", mean, missing);
                return;
            end
            r = expected_means.pop_front();
            if (mean !== r.mean || missing !== r.missing)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: mean expected %h/%b, got %h/%b",
                             r.mean, r.missing, mean, missing);
            end
        endfunction

        function int pending();
            return expected_means.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample;
    logic                 series_start;
    logic                 out_valid;
    logic                 out_stall;
    logic [SAMPLE_W-1:0]  mean;
    logic                 mean_missing;

    mean_scoreboard sb;
    bit             quiet;
    int             cycles;

    moving_mean_with_missing_values i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .series_start (series_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean         (mean),
        .mean_missing (mean_missing)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check every output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_mean(mean, mean_missing);
    end

    // Random back-pressure on the output, mostly short with a few long stalls.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (quiet || $urandom_range(0, 99) < 65)
                out_stall = 1'b0;
            else
            begin
                out_stall  = 1'b1;
                stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                       : $urandom_range(9, 39);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one sample and wait for its transfer; returns at a falling edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        sample       = s;
        series_start = start;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_mean(s, start);
        @(negedge clk);
    endtask

    // Wait until every result has come back and the block is free again.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() > 0 || in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SAMPLE_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.apply_register(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return sb.miss_val;
        if (r < 22)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 60)
            return SAMPLE_W'(int'($urandom_range(0, 2000000)) - 1000000);
        return $urandom;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sentinel();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return SAMPLE_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [LEN_W-1:0]    len;
        logic [SAMPLE_W-1:0] upper;
        int                  eff_len;
        sb           = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample       = '0;
        series_start = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: largest values, a missing current sample, warm-up
        // after a restart, and a mean that truncates toward zero.
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0007, 1'b0);
        drain();

        // Window length of zero acts as one; the most negative value is valid.
        write_register(REG_WINDOW_LEN, 32'h0000_0000);
        write_register(REG_MISSING_VALUE, 32'h0000_0000);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
        drain();

        // Upper data bits beyond the length field are dropped.
        write_register(REG_WINDOW_LEN, 32'hFFFF_FF82);
        write_register(REG_MISSING_VALUE, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFD, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0004, 1'b0);
        send_sample(32'hFFFF_FFF9, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        drain();

        // Random phases, each under new register settings; series carry over.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       len = 7'd1;
                1:       len = 7'd64;
                2:       len = LEN_W'($urandom_range(65, 127));
                3:       len = 7'd0;
                default: len = LEN_W'($urandom_range(2, 16));
            endcase
            upper = $urandom;
            write_register(REG_WINDOW_LEN, {upper[SAMPLE_W-1:LEN_W], len});
            write_register(REG_MISSING_VALUE, pick_sentinel());
            quiet   = ($urandom_range(0, 3) == 0);
            eff_len = (len == 0) ? 1 : ((len > DEPTH) ? DEPTH : int'(len));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample(), $urandom_range(0, 3 * eff_len + 8) == 0);
            drain();
        end

        quiet = 1'b0;
        repeat (150) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
src/mmmv_pkg.sv
src/mmmv_ram.sv
src/moving_mean_with_missing_values.sv
tb/tb_moving_mean_with_missing_values.sv
